>>> src/blre_pkg.sv
// ----------------------------------------------------------------------------
// blre_pkg
// Shared types and constants of the bilevel line run encoder.
// ----------------------------------------------------------------------------
package blre_pkg;

	localparam int WORD_W    = 16;
	localparam int LANES     = 8;
	localparam int MAX_WORDS = 12;
	localparam int WIDX_W    = 4;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int Q_CNT_W   = 3;
	localparam int CIDX_W    = 4;

	localparam logic [WORD_W-1:0] LINE_END_CODE   = 16'hFFF0;
	localparam logic [WORD_W-1:0] RASTER_END_CODE = 16'hFFF2;

	localparam logic [CIDX_W-1:0] REG_LINE_WIDTH   = 4'd0;
	localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

	localparam logic [WORD_W-1:0] LINE_WIDTH_RST   = 16'd1024;
	localparam logic [WORD_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;

	typedef struct packed {
		logic              start;
		logic              close;
		logic [WORD_W-1:0] pos;
	} lane_t;

	typedef struct packed {
		logic [MAX_WORDS-1:0][WORD_W-1:0] words;
		logic [WIDX_W-1:0]                count;
	} group_t;

endpackage

>>> src/blre_lane.sv
// ----------------------------------------------------------------------------
// blre_lane
// One pixel lane: position, width check and run start/close detection.
// ----------------------------------------------------------------------------
module blre_lane #(
	parameter int LANE = 0
) (
	input  logic [blre_pkg::WORD_W-1:0] base,
	input  logic [blre_pkg::WORD_W-1:0] width,
	input  logic                        pixel,
	input  logic                        open_in,
	output blre_pkg::lane_t             res,
	output logic                        open_out
);

	logic [blre_pkg::WORD_W-1:0] pos;
	logic                        inside_line;

	assign pos         = base + blre_pkg::WORD_W'(LANE + 1);
	assign inside_line = (pos <= width);

	assign res.pos   = pos;
	assign res.start = inside_line & pixel & ~open_in;
	assign res.close = inside_line & ~pixel & open_in;
	assign open_out  = inside_line ? pixel : open_in;

endmodule

>>> src/blre_merge.sv
// ----------------------------------------------------------------------------
// blre_merge
// Combines the lane results of one byte into an ordered group of code words.
// ----------------------------------------------------------------------------
module blre_merge (
	input  blre_pkg::lane_t [blre_pkg::LANES-1:0] lanes,
	input  logic [blre_pkg::WORD_W-1:0]           first_in,
	input  logic [blre_pkg::WORD_W-1:0]           width,
	input  logic                                  tail,
	input  logic                                  line_end,
	input  logic                                  last_line,
	output blre_pkg::group_t                      grp
);

	always_comb begin
		logic [blre_pkg::WIDX_W-1:0] k;
		logic [blre_pkg::WORD_W-1:0] f;
		k = '0;
		f = first_in;
		grp.words = '0;
		for (int i = 0; i < blre_pkg::LANES; i++) begin
			if (lanes[i].start) begin
				f = lanes[i].pos;
			end
			if (lanes[i].close) begin
				grp.words[k] = f;
				grp.words[blre_pkg::WIDX_W'(k + 4'd1)] = lanes[i].pos - 16'd1;
				k = blre_pkg::WIDX_W'(k + 4'd2);
			end
		end
		// run still open at the line end stops at the width
		if (tail) begin
			grp.words[k] = f;
			grp.words[blre_pkg::WIDX_W'(k + 4'd1)] = width;
			k = blre_pkg::WIDX_W'(k + 4'd2);
		end
		if (line_end) begin
			grp.words[k] = blre_pkg::LINE_END_CODE;
			grp.words[blre_pkg::WIDX_W'(k + 4'd1)] =
				last_line ? blre_pkg::RASTER_END_CODE : blre_pkg::LINE_END_CODE;
			k = blre_pkg::WIDX_W'(k + 4'd2);
		end
		grp.count = k;
	end

endmodule

>>> src/blre_queue.sv
// ----------------------------------------------------------------------------
// blre_queue
// Queue of word groups; its serializer hands out one word per unstalled cycle.
// ----------------------------------------------------------------------------
module blre_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  blre_pkg::group_t            push_grp,
	output logic                        full,
	output logic                        code_valid,
	input  logic                        code_stall,
	output logic [blre_pkg::WORD_W-1:0] code_word,
	output logic                        last_word
);

	blre_pkg::group_t                 mem_q [blre_pkg::Q_DEPTH];
	logic [blre_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [blre_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [blre_pkg::Q_CNT_W-1:0]     cnt_q;
	logic [blre_pkg::WIDX_W-1:0]      idx_q;
	blre_pkg::group_t                 head;
	logic                             take;
	logic                             pop;

	assign head       = mem_q[rd_ptr_q];
	assign full       = (cnt_q == blre_pkg::Q_CNT_W'(blre_pkg::Q_DEPTH));
	assign code_valid = (cnt_q != '0);
	assign code_word  = head.words[idx_q];
	assign last_word  = (idx_q == head.count - 4'd1);
	assign take       = code_valid & ~code_stall;
	assign pop        = take & last_word;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= blre_pkg::Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= blre_pkg::Q_PTR_W'(rd_ptr_q + 1'b1);
				idx_q    <= '0;
			end else if (take) begin
				idx_q <= blre_pkg::WIDX_W'(idx_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= blre_pkg::Q_CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= blre_pkg::Q_CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

>>> src/bilevel_line_run_encoder.sv
// ----------------------------------------------------------------------------
// bilevel_line_run_encoder
// Start/stop run-length encoder for a 1-bit raster, eight pixels per request.
//
// The pixel channel (pixel_valid, pixel_stall, pixel_byte) takes one byte of
// eight pixels, bit 7 leftmost. The code channel (code_valid, code_stall,
// code_word, last_word) returns, per byte, the start and stop positions of
// every run that closes in it, then the two line markers after the byte that
// ends a line. last_word marks the final word of each byte's group.
// Eight pixel lanes evaluate a byte combinationally; a merge stage orders the
// words of the byte into a group and a four-group queue feeds the serializer.
// A byte's words pass the stage-1 registers and the queue to code_word. A
// byte is taken every cycle while the queue has room; the code channel moves
// one word per cycle while code_stall is low. A stall on the code channel holds
// the current word; pixel_stall rises when the queue is full and the staged byte
// has words to push. Bytes that yield no words never enter the queue. Reset sets
// line_width and image_height to 1024, clears the pixel, run and line counters
// and empties the queue. Registers are written through cfg_write, cfg_index
// and cfg_data while the block is idle; the user must ensure it, nothing checks.
// ----------------------------------------------------------------------------
module bilevel_line_run_encoder #(
	parameter int MAX_LINE_PIXELS = 32768
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [blre_pkg::CIDX_W-1:0] cfg_index,
	input  logic [blre_pkg::WORD_W-1:0] cfg_data,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [7:0]                  pixel_byte,
	output logic                        code_valid,
	input  logic                        code_stall,
	output logic [blre_pkg::WORD_W-1:0] code_word,
	output logic                        last_word
);

	localparam int POS_W = $clog2(MAX_LINE_PIXELS + 8);
	localparam logic [blre_pkg::WORD_W-1:0] MAX_W = blre_pkg::WORD_W'(MAX_LINE_PIXELS);

	logic [blre_pkg::WORD_W-1:0] line_width_q;
	logic [blre_pkg::WORD_W-1:0] image_height_q;
	logic [POS_W-1:0]            pixel_count_q;
	logic                        run_open_q;
	logic [POS_W-1:0]            run_first_q;
	logic [blre_pkg::WORD_W-1:0] line_count_q;

	logic [blre_pkg::WORD_W-1:0] width;
	logic [blre_pkg::WORD_W-1:0] base;
	logic [blre_pkg::WORD_W-1:0] consumed;
	logic                        line_end;
	logic                        last_line;
	logic                        tail;
	logic [blre_pkg::WORD_W-1:0] first_final;
	logic                        accept;
	logic                        q_full;
	logic                        push;

	blre_pkg::lane_t [blre_pkg::LANES-1:0] lanes;
	logic [blre_pkg::LANES:0]              open_chain;

	logic                                  valid_s1;
	blre_pkg::lane_t [blre_pkg::LANES-1:0] lanes_s1;
	logic [blre_pkg::WORD_W-1:0]           first_s1;
	logic [blre_pkg::WORD_W-1:0]           width_s1;
	logic                                  tail_s1;
	logic                                  line_end_s1;
	logic                                  last_s1;
	blre_pkg::group_t                      grp;

	assign width    = (line_width_q > MAX_W) ? MAX_W : line_width_q;
	assign base     = blre_pkg::WORD_W'(pixel_count_q);
	assign consumed = base + 16'd8;
	assign line_end = (consumed >= width);
	assign last_line = ({1'b0, line_count_q} + 17'd1) >= {1'b0, image_height_q};

	assign open_chain[0] = run_open_q;

	for (genvar i = 0; i < blre_pkg::LANES; i++) begin : g_lane
		blre_lane #(
			.LANE(i)
		) u_lane (
			.base    (base),
			.width   (width),
			.pixel   (pixel_byte[blre_pkg::LANES-1-i]),
			.open_in (open_chain[i]),
			.res     (lanes[i]),
			.open_out(open_chain[i+1])
		);
	end

	always_comb begin
		first_final = blre_pkg::WORD_W'(run_first_q);
		for (int i = 0; i < blre_pkg::LANES; i++) begin
			if (lanes[i].start) begin
				first_final = lanes[i].pos;
			end
		end
	end

	// open run whose start lies past a shrunk width is dropped
	assign tail = line_end & open_chain[blre_pkg::LANES] & (first_final <= width);

	assign pixel_stall = valid_s1 & (grp.count != '0) & q_full;
	assign accept      = pixel_valid & ~pixel_stall;
	assign push        = valid_s1 & (grp.count != '0) & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= blre_pkg::LINE_WIDTH_RST;
			image_height_q <= blre_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				blre_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				blre_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
			run_open_q    <= 1'b0;
			run_first_q   <= '0;
			line_count_q  <= '0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & pixel_stall);
			if (accept) begin
				if (line_end) begin
					pixel_count_q <= '0;
					run_open_q    <= 1'b0;
					run_first_q   <= '0;
					line_count_q  <= last_line ? '0 : line_count_q + 16'd1;
				end else begin
					pixel_count_q <= POS_W'(consumed);
					run_open_q    <= open_chain[blre_pkg::LANES];
					run_first_q   <= POS_W'(first_final);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_s1    <= lanes;
			first_s1    <= blre_pkg::WORD_W'(run_first_q);
			width_s1    <= width;
			tail_s1     <= tail;
			line_end_s1 <= line_end;
			last_s1     <= last_line;
		end
	end

	blre_merge u_merge (
		.lanes    (lanes_s1),
		.first_in (first_s1),
		.width    (width_s1),
		.tail     (tail_s1),
		.line_end (line_end_s1),
		.last_line(last_s1),
		.grp      (grp)
	);

	blre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_grp  (grp),
		.full      (q_full),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_word (code_word),
		.last_word (last_word)
	);

endmodule

>>> dv/tb_bilevel_line_run_encoder.sv
// ----------------------------------------------------------------------------
// tb_bilevel_line_run_encoder
// Self-checking bench for the bilevel line run encoder. A directed table walks
// the width and height extremes, padding, runs cut at the line end, a width
// shrunk mid-line, zero width and height and ignored register indexes, then
// random lines of random width follow. Each accepted byte runs through a local
// run coder; its start, stop and marker words, or a typed row's words, are
// matched in order against the code channel amid code stalls and valid gaps.
// ----------------------------------------------------------------------------
module tb_bilevel_line_run_encoder;

	localparam int CLK_HALF       = 10;
	localparam int LINE_CAP       = 32768;
	localparam int RAND_ITEMS     = 310;
	localparam int CALM_ITEMS     = 260;
	localparam int DRAIN_CYCLES   = 6;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int MAX_REPORTS    = 10;
	localparam int ROW_BITS       = blre_pkg::MAX_WORDS * blre_pkg::WORD_W;

	localparam logic [blre_pkg::CIDX_W-1:0] REG_INDEX_MAX = '1;

	typedef enum logic [1:0] {ROW_REG, ROW_BYTE, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [blre_pkg::CIDX_W-1:0] idx;
		logic [blre_pkg::WORD_W-1:0] data;
		logic [blre_pkg::WIDX_W-1:0] n;
		logic [ROW_BITS-1:0]         words;
	} row_t;

	typedef struct packed {
		logic [blre_pkg::WORD_W-1:0] word;
		logic                        last;
	} code_rec_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_write   = 1'b0;
	logic [blre_pkg::CIDX_W-1:0] cfg_index   = '0;
	logic [blre_pkg::WORD_W-1:0] cfg_data    = '0;
	logic                        pixel_valid = 1'b0;
	logic                        pixel_stall;
	logic [7:0]                  pixel_byte  = '0;
	logic                        code_valid;
	logic                        code_stall  = 1'b0;
	logic [blre_pkg::WORD_W-1:0] code_word;
	logic                        last_word;

	// local copy of the encoder registers and state
	logic [blre_pkg::WORD_W-1:0] mir_width  = blre_pkg::LINE_WIDTH_RST;
	logic [blre_pkg::WORD_W-1:0] mir_height = blre_pkg::IMAGE_HEIGHT_RST;
	logic [blre_pkg::WORD_W-1:0] pix_done   = '0;
	logic                        run_on     = 1'b0;
	logic [blre_pkg::WORD_W-1:0] run_head   = '0;
	logic [blre_pkg::WORD_W-1:0] lines_done = '0;

	logic [blre_pkg::WORD_W-1:0] fresh[$];
	code_rec_t                   code_due[$];
	code_rec_t                   due;
	row_t                        plan[$];

	int err_count  = 0;
	int stall_left = 0;
	bit gaps_on    = 1'b1;
	bit calm       = 1'b0;

	bilevel_line_run_encoder #(
		.MAX_LINE_PIXELS(LINE_CAP)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_byte (pixel_byte),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_word  (code_word),
		.last_word  (last_word)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	initial begin
		#(2 * CLK_HALF * TIMEOUT_CYCLES);
		$display("FAILURE");
		$finish;
	end

	// run coder: words caused by one pixel byte, left in fresh
	task automatic encode_byte(input logic [7:0] px);
		int unsigned w;
		int unsigned pos;
		bit          last_line;
		fresh.delete();
		w = (32'(mir_width) > LINE_CAP) ? LINE_CAP : 32'(mir_width);
		for (int i = 0; i < 8; i++) begin
			pos = 32'(pix_done) + 32'(i) + 1;
			if (pos <= w) begin
				if (px[7 - i] && !run_on) begin
					run_on   = 1'b1;
					run_head = pos[blre_pkg::WORD_W-1:0];
				end else if (!px[7 - i] && run_on) begin
					fresh.push_back(run_head);
					fresh.push_back(16'(pos - 1));
					run_on = 1'b0;
				end
			end
		end
		if (32'(pix_done) + 8 >= w) begin
			last_line = (32'(lines_done) + 1 >= 32'(mir_height));
			if (run_on && 32'(run_head) <= w) begin
				fresh.push_back(run_head);
				fresh.push_back(w[blre_pkg::WORD_W-1:0]);
			end
			run_on   = 1'b0;
			run_head = '0;
			fresh.push_back(blre_pkg::LINE_END_CODE);
			fresh.push_back(last_line ? blre_pkg::RASTER_END_CODE : blre_pkg::LINE_END_CODE);
			lines_done = last_line ? '0 : lines_done + 1'b1;
			pix_done   = '0;
		end else begin
			pix_done = pix_done + 16'd8;
		end
	endtask

	task automatic flag_err(input string what, input code_rec_t want);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s: expected %h/%0b got %h/%0b", $realtime, what,
				want.word, want.last, code_word, last_word);
	endtask

	always @(posedge clk) begin
		if (arst_n && code_valid && !code_stall) begin
			if (code_due.size() == 0) begin
				flag_err("word with nothing pending", '0);
			end else begin
				due = code_due.pop_front();
				if (code_word !== due.word || last_word !== due.last)
					flag_err("code mismatch", due);
			end
		end
	end

	// code channel stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			code_stall <= 1'b1;
		end else if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			code_stall <= 1'b1;
		end else begin
			code_stall <= 1'b0;
		end
	end

	function automatic row_t mk_row(input row_kind_t kind,
			input logic [blre_pkg::CIDX_W-1:0] idx,
			input logic [blre_pkg::WORD_W-1:0] data, input int n,
			input logic [ROW_BITS-1:0] words);
		row_t r;
		r.kind  = kind;
		r.idx   = idx;
		r.data  = data;
		r.n     = n[blre_pkg::WIDX_W-1:0];
		r.words = words;
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom & $urandom);
			3: return 8'($urandom | $urandom);
			default: return 8'($urandom);
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] px, input bit typed, input int n,
			input logic [ROW_BITS-1:0] words);
		code_rec_t rec;
		int        cnt;
		if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_byte  <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		encode_byte(px);
		cnt = typed ? n : fresh.size();
		for (int k = 0; k < cnt; k++) begin
			rec.word = typed ? words[(n - 1 - k) * blre_pkg::WORD_W +: blre_pkg::WORD_W]
				: fresh[k];
			rec.last = (k == cnt - 1);
			code_due.push_back(rec);
		end
		@(negedge clk);
	endtask

	task automatic settle();
		pixel_valid <= 1'b0;
		while (code_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [blre_pkg::CIDX_W-1:0] idx,
			input logic [blre_pkg::WORD_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == blre_pkg::REG_LINE_WIDTH)
			mir_width = val;
		else if (idx == blre_pkg::REG_IMAGE_HEIGHT)
			mir_height = val;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int                          rand_sent;
		int                          nb;
		int                          bpl;
		int unsigned                 eff;
		logic [blre_pkg::WORD_W-1:0] w;
		logic [blre_pkg::WORD_W-1:0] h;

		// reset width and height, line begun with a run left open
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h00, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hFF, 0, '0));
		// width shrunk below the open run: run dropped, line ends
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'd8, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hFF, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hFF, 4,
			{16'd1, 16'd8, blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hAA, 10,
			{16'd1, 16'd1, 16'd3, 16'd3, 16'd5, 16'd5, 16'd7, 16'd7,
			blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h55, 10,
			{16'd2, 16'd2, 16'd4, 16'd4, 16'd6, 16'd6, 16'd8, 16'd8,
			blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h00, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		// single-line raster
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_IMAGE_HEIGHT, 16'd1, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h81, 6,
			{16'd1, 16'd1, 16'd8, 16'd8, blre_pkg::LINE_END_CODE,
			blre_pkg::RASTER_END_CODE}));
		// one pixel per line, rest is padding
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'd1, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h80, 4,
			{16'd1, 16'd1, blre_pkg::LINE_END_CODE, blre_pkg::RASTER_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h7F, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::RASTER_END_CODE}));
		// zero width and zero height
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'd0, 0, '0));
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_IMAGE_HEIGHT, 16'd0, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hFF, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::RASTER_END_CODE}));
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_IMAGE_HEIGHT, 16'd3, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h00, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h00, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h00, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::RASTER_END_CODE}));
		// writes to unused indexes change nothing
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_IMAGE_HEIGHT + 1'b1, 16'h1234, 0, '0));
		plan.push_back(mk_row(ROW_REG, REG_INDEX_MAX, 16'hFFFF, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hFF, 2,
			{blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		// width not a multiple of eight, run up to the line end
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'd12, 0, '0));
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_IMAGE_HEIGHT, 16'hFFFF, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hF0, 2, {16'd1, 16'd4}));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h3F, 4,
			{16'd11, 16'd12, blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));
		plan.push_back(mk_row(ROW_BYTE, '0, 16'h5A, 0, '0));
		// oversized widths, then shrunk under an open run
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'hFFFF, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h01, 0, '0));
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'd65519, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'hFF, 0, '0));
		plan.push_back(mk_row(ROW_REG, blre_pkg::REG_LINE_WIDTH, 16'd20, 0, '0));
		plan.push_back(mk_row(ROW_TYPED, '0, 16'h00, 4,
			{16'd16, 16'd20, blre_pkg::LINE_END_CODE, blre_pkg::LINE_END_CODE}));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_REG) begin
				settle();
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				send_byte(plan[r].data[7:0], plan[r].kind == ROW_TYPED, plan[r].n,
					plan[r].words);
			end
		end

		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			settle();
			gaps_on <= ($urandom_range(0, 3) != 0);
			calm    <= (rand_sent >= CALM_ITEMS);
			case ($urandom_range(0, 9))
				0: w = 16'($urandom_range(0, 8));
				1, 2, 3, 4, 5: w = 16'($urandom_range(1, 64));
				6, 7: w = 16'($urandom_range(65, 256));
				8: w = $urandom_range(0, 1) ? 16'd65519 : 16'hFFFF;
				default: w = 16'($urandom);
			endcase
			write_reg(blre_pkg::REG_LINE_WIDTH, w);
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
					0: h = 16'd0;
					1: h = 16'd1;
					2: h = 16'hFFFF;
					3: h = 16'($urandom);
					default: h = 16'($urandom_range(2, 5));
				endcase
				write_reg(blre_pkg::REG_IMAGE_HEIGHT, h);
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(blre_pkg::CIDX_W'($urandom_range(blre_pkg::REG_IMAGE_HEIGHT + 1,
					REG_INDEX_MAX)), 16'($urandom));
			eff = (32'(w) > LINE_CAP) ? LINE_CAP : 32'(w);
			bpl = (eff == 0) ? 1 : int'((eff + 7) / 8);
			if (bpl <= 32) begin
				nb = bpl * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0)
					nb += $urandom_range(1, bpl);
			end else begin
				nb = $urandom_range(1, 12);
			end
			if (nb > RAND_ITEMS - rand_sent)
				nb = RAND_ITEMS - rand_sent;
			repeat (nb) begin
				send_byte(pick_byte(), 1'b0, 0, '0);
				rand_sent++;
			end
		end

		settle();
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
